FILE: hw/rtl/sma_pkg.sv
// ---------------------------------------------------------------------------
// sma_pkg: shared types and constants of the moving average block
// Register indexes, field widths, parameter defaults and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package sma_pkg;

   // Parameter defaults
   localparam int DEF_MAX_WINDOW    = 32;
   localparam int DEF_SAMPLE_BITS   = 16;
   localparam int DEF_FRACTION_BITS = 8;

   // Fixed field widths
   localparam int AVG_BITS       = 24;
   localparam int WLEN_BITS      = 6;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 6;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WEIGHTED_MODE = 1'd1;

   // Register reset values
   localparam logic [WLEN_BITS-1:0] WINDOW_LENGTH_RESET = 6'd4;
   localparam logic                 WEIGHTED_MODE_RESET = 1'b0;

   // Controller to datapath
   typedef struct packed {
      logic load;       // store the accepted sample, set up the window walk
      logic sum_run;    // walk the window and accumulate
      logic div_start;  // load the divider
      logic div_step;   // one quotient bit
      logic out_load;   // load the output register
   } sma_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic have_result;  // window holds at least n samples
      logic sum_done;     // walk finished, sums final
      logic div_done;     // all quotient bits formed
   } sma_stat_type;

endpackage

FILE: hw/rtl/sma_dp.sv
// ---------------------------------------------------------------------------
// sma_dp: moving average datapath
// Window memory, configuration registers, running sums over the window,
// a restoring divider one bit per cycle and the output register.
// ---------------------------------------------------------------------------
module sma_dp #(
   parameter int MAX_WINDOW    = sma_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS   = sma_pkg::DEF_SAMPLE_BITS,
   parameter int FRACTION_BITS = sma_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sma_pkg::sma_cmd_type                cmd,
   output sma_pkg::sma_stat_type               stat,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic                                req_restart,
   input  logic                                csr_write,
   input  logic [sma_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sma_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output logic signed [sma_pkg::AVG_BITS-1:0] rsp_average
);

   localparam int AW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int NB        = $clog2(MAX_WINDOW + 1);
   localparam int XW        = NB + 1;
   localparam int DEN_BITS  = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + NB;
   localparam int WSUM_BITS = SAMPLE_BITS + DEN_BITS;
   localparam int DVD_BITS  = WSUM_BITS + FRACTION_BITS;
   localparam int CNT_BITS  = $clog2(DVD_BITS + 1);
   localparam int AVB       = sma_pkg::AVG_BITS;
   localparam int CMP_BITS  = (DVD_BITS > AVB) ? DVD_BITS : AVB + 1;
   localparam logic [CMP_BITS-1:0] POS_LIMIT = CMP_BITS'((64'd1 << (AVB - 1)) - 64'd1);
   localparam logic [CMP_BITS-1:0] NEG_LIMIT = CMP_BITS'(64'd1 << (AVB - 1));

   // Window memory
   logic signed [SAMPLE_BITS-1:0] window_mem_ff [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   // Configuration
   logic [sma_pkg::WLEN_BITS-1:0] wlen_ff;
   logic                          mode_ff;

   // Window bookkeeping
   logic [AW-1:0] wp_ff, wp_in;
   logic [NB-1:0] fill_ff, fill_in, fill_base;
   logic [NB-1:0] n_ff, n_eff;
   logic [AW-1:0] rd_addr_ff, rd_addr_in, rd_start;
   logic [NB-1:0] rd_left_ff;
   logic          rd_valid_ff;
   logic          rd_issue;
   logic [XW-1:0] wp_ext, n_ext;

   // Sums
   logic signed [SUM_BITS-1:0]  psum_ff, psum_in;
   logic signed [WSUM_BITS-1:0] wsum_ff, num;
   logic [WSUM_BITS-1:0]        num_mag;

   // Divider
   logic [2*NB-1:0]     tri_prod;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff;
   logic [DEN_BITS:0]   rem_shift;
   logic                rem_ge;
   logic [DVD_BITS-1:0] quo_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                neg_ff;

   // Output
   logic [CMP_BITS-1:0]    q_ext;
   logic signed [AVB-1:0]  avg_ff, avg_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= sma_pkg::WINDOW_LENGTH_RESET;
         mode_ff <= sma_pkg::WEIGHTED_MODE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sma_pkg::REG_WINDOW_LENGTH: wlen_ff <= csr_data;
            sma_pkg::REG_WEIGHTED_MODE: mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Effective window length, clamped to 1..MAX_WINDOW
   always_comb begin
      if (wlen_ff == '0) begin
         n_eff = NB'(1);
      end else if (32'(wlen_ff) > MAX_WINDOW) begin
         n_eff = NB'(MAX_WINDOW);
      end else begin
         n_eff = NB'(wlen_ff);
      end
   end

   // Write pointer, fill count and start of the window walk
   always_comb begin
      wp_in     = (wp_ff == AW'(MAX_WINDOW - 1)) ? '0 : wp_ff + 1'b1;
      fill_base = req_restart ? '0 : fill_ff;
      fill_in   = (fill_base < NB'(MAX_WINDOW)) ? fill_base + 1'b1 : fill_base;
      wp_ext    = XW'(wp_in);
      n_ext     = XW'(n_eff);
      if (n_ext > wp_ext) begin
         rd_start = AW'(wp_ext + XW'(MAX_WINDOW) - n_ext);
      end else begin
         rd_start = AW'(wp_ext - n_ext);
      end
      rd_addr_in = (rd_addr_ff == AW'(MAX_WINDOW - 1)) ? '0 : rd_addr_ff + 1'b1;
      rd_issue   = cmd.sum_run && (rd_left_ff != '0);
   end

   // Control state of the window walk
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         fill_ff     <= '0;
         rd_left_ff  <= '0;
         rd_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         rd_valid_ff <= rd_issue;
         if (cmd.load) begin
            wp_ff      <= wp_in;
            fill_ff    <= fill_in;
            rd_left_ff <= n_eff;
         end else if (rd_issue) begin
            rd_left_ff <= rd_left_ff - 1'b1;
         end
         if (cmd.div_start) begin
            cnt_ff <= CNT_BITS'(DVD_BITS);
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // Window memory: write on accept, registered read during the walk
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         window_mem_ff[wp_ff] <= req_sample;
      end
      if (rd_issue) begin
         rd_data_ff <= window_mem_ff[rd_addr_ff];
      end
   end

   // Running sums: weighted sum gathers the prefix sums, oldest first,
   // which gives the oldest sample weight n and the newest weight 1
   assign psum_in = psum_ff + SUM_BITS'(rd_data_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff       <= n_eff;
         rd_addr_ff <= rd_start;
         psum_ff    <= '0;
         wsum_ff    <= '0;
      end else begin
         if (rd_issue) begin
            rd_addr_ff <= rd_addr_in;
         end
         if (rd_valid_ff) begin
            psum_ff <= psum_in;
            wsum_ff <= wsum_ff + WSUM_BITS'(psum_in);
         end
      end
   end

   // Divider operands
   always_comb begin
      tri_prod = {NB'(0), n_ff} * ({NB'(0), n_ff} + 1'b1);
      den_in   = mode_ff ? DEN_BITS'(tri_prod >> 1) : DEN_BITS'(n_ff);
      num      = mode_ff ? wsum_ff : WSUM_BITS'(psum_ff);
      num_mag  = num[WSUM_BITS-1] ? -num : num;
   end

   // Restoring divide step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_BITS-1]};
      rem_ge    = rem_shift >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         den_ff <= den_in;
         rem_ff <= '0;
         neg_ff <= num[WSUM_BITS-1];
         quo_ff <= DVD_BITS'(num_mag) << FRACTION_BITS;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? DEN_BITS'(rem_shift - {1'b0, den_ff}) : DEN_BITS'(rem_shift);
         quo_ff <= {quo_ff[DVD_BITS-2:0], rem_ge};
      end
   end

   // Sign, saturation and output register
   always_comb begin
      q_ext = CMP_BITS'(quo_ff);
      if (!neg_ff && (q_ext > POS_LIMIT)) begin
         avg_in = AVB'(POS_LIMIT);
      end else if (neg_ff && (q_ext > NEG_LIMIT)) begin
         avg_in = AVB'(NEG_LIMIT);
      end else if (neg_ff) begin
         avg_in = -AVB'(q_ext);
      end else begin
         avg_in = AVB'(q_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         avg_ff <= avg_in;
      end
   end

   assign rsp_average      = avg_ff;
   assign stat.have_result = fill_ff >= n_ff;
   assign stat.sum_done    = (rd_left_ff == '0) && !rd_valid_ff;
   assign stat.div_done    = cnt_ff == '0;

endmodule

FILE: hw/rtl/sma_ctrl.sv
// ---------------------------------------------------------------------------
// sma_ctrl: moving average controller
// Sequences one beat through store, window walk, divide and output, and
// owns the handshakes of both channels.
// ---------------------------------------------------------------------------
module sma_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sma_pkg::sma_cmd_type  cmd,
   input  sma_pkg::sma_stat_type stat
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.have_result ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            if (stat.sum_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.sum_run = 1'b1;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on load, cleared when the beat is taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = out_valid_ff;

endmodule

FILE: hw/rtl/simple_or_weighted_moving_average.sv
// ---------------------------------------------------------------------------
// simple_or_weighted_moving_average: sliding window mean, simple or weighted
// Input beats (req_) carry a signed sample and a restart flag; once the
// series holds n samples (window_length clamped), every input beat yields one
// result beat (rsp_) with the window mean, 8 fraction bits, truncated toward
// zero. Weighted mode gives the oldest sample weight n, the newest weight 1.
// Configuration (csr_) is always ready; write it only while the block idles.
// Sequence: an input beat that gives no result frees the input after the
// check state. One that does walks the window (one memory read per
// sample), steps the restoring divider over every dividend bit (34 with
// default parameters) and loads the output register: the result turns
// valid in the cycle in which the block is back in idle, so the next beat
// can be accepted in that same cycle. One beat is processed at a
// time; req_stall is high from the cycle after accept until the block is
// back in idle.
// The output register lets the next beat be accepted while a result waits;
// a held rsp_stall stalls the block only when a second result is ready.
// Reset clears the series (no window held), the pointers and the output
// valid, and sets window_length to 4 and weighted_mode to 0.
// ---------------------------------------------------------------------------
module simple_or_weighted_moving_average #(
   parameter int MAX_WINDOW    = sma_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS   = sma_pkg::DEF_SAMPLE_BITS,
   parameter int FRACTION_BITS = sma_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sma_pkg::AVG_BITS-1:0] rsp_average,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sma_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sma_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   sma_pkg::sma_cmd_type  cmd;
   sma_pkg::sma_stat_type stat;
   logic                  csr_write;

   // Register writes are always accepted
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   sma_dp #(
      .MAX_WINDOW    (MAX_WINDOW),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_sample  (req_sample),
      .req_restart (req_restart),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_average (rsp_average)
   );

endmodule
